// ===== hdl/bvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvc_pkg
// shared types, widths and helpers for the box versus collider contact test
// ----------------------------------------------------------------------------
package bvc_pkg;

  localparam int unsigned DW         = 25;  // signed offset centre - clamp
  localparam int unsigned SUMW       = 50;  // sum of squares
  localparam int unsigned ROOTW      = 25;  // floored distance
  localparam int unsigned SQ_STAGES  = 25;  // one root bit per stage
  localparam int unsigned QW         = 15;  // normal magnitude bits
  localparam int unsigned DIV_STAGES = QW;  // one quotient bit per stage
  localparam int unsigned NUMW       = 40;  // dividend and shifted divisor
  localparam int unsigned LATENCY    = SQ_STAGES + DIV_STAGES + 4;

  localparam logic signed [15:0] UNIT_NORMAL = 16'sd16384;
  localparam logic signed [15:0] NEG_NORMAL  = -16'sd16384;
  localparam logic [22:0]        DEPTH_MAX   = 23'h7fffff;

  typedef struct packed {
    logic signed [23:0] box_min_x;
    logic signed [23:0] box_min_y;
    logic signed [23:0] box_max_x;
    logic signed [23:0] box_max_y;
    logic               is_circle;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic        [22:0] radius;
    logic        [22:0] size_x;
    logic        [22:0] size_y;
  } req_t;

  typedef struct packed {
    logic               colliding;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic        [22:0] depth;
  } res_t;

  // travels beside the square root
  typedef struct packed {
    logic                 is_circle;
    res_t                 box_res;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic        [22:0]   radius;
  } sq_side_t;

  // travels beside the dividers
  typedef struct packed {
    res_t res;
    logic use_div;
    logic neg_x;
    logic neg_y;
  } dv_side_t;

  function automatic logic signed [27:0] ext28(input logic signed [23:0] v);
    ext28 = {{4{v[23]}}, v};
  endfunction

  function automatic logic signed [27:0] dbl28(input logic signed [23:0] v);
    dbl28 = {{3{v[23]}}, v, 1'b0};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bvc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvc_front
// clamp, box overlap test and sum of squares, two register stages
// ----------------------------------------------------------------------------
module bvc_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire bvc_pkg::req_t           req_i,
  output logic                         valid_o,
  output logic [bvc_pkg::SUMW-1:0]     sum_o,
  output bvc_pkg::sq_side_t            side_o
);
  import bvc_pkg::*;

  logic signed [23:0] lo_x, lo_y, qx, qy;
  logic signed [DW-1:0] dx_d, dy_d;
  logic signed [27:0] omin_x, omax_x, omin_y, omax_y;
  logic signed [27:0] hi_x, hi_y, lo2_x, lo2_y, ov_x, ov_y, half;
  logic signed [27:0] c2x, c2y;
  res_t box_d;
  logic hit;

  logic                 valid_a_q;
  sq_side_t             side_a_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [SUMW-1:0] px, py;

  always_comb begin
    lo_x = (req_i.center_x < req_i.box_max_x) ? req_i.center_x : req_i.box_max_x;
    qx   = (req_i.box_min_x > lo_x) ? req_i.box_min_x : lo_x;
    lo_y = (req_i.center_y < req_i.box_max_y) ? req_i.center_y : req_i.box_max_y;
    qy   = (req_i.box_min_y > lo_y) ? req_i.box_min_y : lo_y;
    dx_d = $signed({req_i.center_x[23], req_i.center_x}) - $signed({qx[23], qx});
    dy_d = $signed({req_i.center_y[23], req_i.center_y}) - $signed({qy[23], qy});

    c2x    = dbl28(req_i.center_x);
    c2y    = dbl28(req_i.center_y);
    omin_x = c2x - $signed({5'b0, req_i.size_x});
    omax_x = c2x + $signed({5'b0, req_i.size_x});
    omin_y = c2y - $signed({5'b0, req_i.size_y});
    omax_y = c2y + $signed({5'b0, req_i.size_y});
    hi_x   = (dbl28(req_i.box_max_x) < omax_x) ? dbl28(req_i.box_max_x) : omax_x;
    lo2_x  = (dbl28(req_i.box_min_x) > omin_x) ? dbl28(req_i.box_min_x) : omin_x;
    hi_y   = (dbl28(req_i.box_max_y) < omax_y) ? dbl28(req_i.box_max_y) : omax_y;
    lo2_y  = (dbl28(req_i.box_min_y) > omin_y) ? dbl28(req_i.box_min_y) : omin_y;
    ov_x   = hi_x - lo2_x;
    ov_y   = hi_y - lo2_y;
    hit    = (ov_x > 28'sd0) && (ov_y > 28'sd0);

    box_d = '0;
    half  = '0;
    if (hit) begin
      box_d.colliding = 1'b1;
      if (ov_x < ov_y) begin
        half = ov_x >>> 1;
        box_d.normal_x = (c2x < (ext28(req_i.box_min_x) + ext28(req_i.box_max_x)))
                         ? NEG_NORMAL : UNIT_NORMAL;
      end else begin
        half = ov_y >>> 1;
        box_d.normal_y = (c2y < (ext28(req_i.box_min_y) + ext28(req_i.box_max_y)))
                         ? NEG_NORMAL : UNIT_NORMAL;
      end
      box_d.depth = (half > $signed({5'b0, DEPTH_MAX})) ? DEPTH_MAX : half[22:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_o   <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_o   <= valid_a_q;
    end
  end

  // squares in the second stage
  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    dx_q               <= dx_d;
    dy_q               <= dy_d;
    side_a_q.is_circle <= req_i.is_circle;
    side_a_q.box_res   <= box_d;
    side_a_q.dx        <= dx_d;
    side_a_q.dy        <= dy_d;
    side_a_q.radius    <= req_i.radius;
    sum_o              <= $unsigned(px) + $unsigned(py);
    side_o             <= side_a_q;
  end

endmodule
`default_nettype wire

// ===== hdl/bvc_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvc_sqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module bvc_sqrt (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic [bvc_pkg::SUMW-1:0] sum_i,
  input  wire bvc_pkg::sq_side_t        side_i,
  output logic                          valid_o,
  output logic [bvc_pkg::ROOTW-1:0]     root_o,
  output bvc_pkg::sq_side_t             side_o
);
  import bvc_pkg::*;

  logic [SQ_STAGES-1:0] vld_q;
  logic [SUMW-1:0]      rem_q  [SQ_STAGES];
  logic [SUMW-1:0]      root_q [SQ_STAGES];
  sq_side_t             side_q [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    localparam logic [SUMW-1:0] BIT = SUMW'(1) << (2 * (SQ_STAGES - 1 - s));
    logic [SUMW-1:0] rem_in, root_in, trial;
    sq_side_t        side_in;
    logic            vld_in;

    if (s == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign trial = root_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[s] <= side_in;
      if (rem_in >= trial) begin
        rem_q[s]  <= rem_in - trial;
        root_q[s] <= (root_in >> 1) + BIT;
      end else begin
        rem_q[s]  <= rem_in;
        root_q[s] <= root_in >> 1;
      end
    end
  end

  assign valid_o = vld_q[SQ_STAGES-1];
  assign root_o  = root_q[SQ_STAGES-1][ROOTW-1:0];
  assign side_o  = side_q[SQ_STAGES-1];

endmodule
`default_nettype wire

// ===== hdl/bvc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvc_div
// two pipelined restoring dividers for the normal, one quotient bit per stage
// ----------------------------------------------------------------------------
module bvc_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire logic [bvc_pkg::NUMW-1:0] num_x_i,
  input  wire logic [bvc_pkg::NUMW-1:0] num_y_i,
  input  wire logic [bvc_pkg::ROOTW-1:0] den_i,
  input  wire bvc_pkg::dv_side_t        side_i,
  output logic                          valid_o,
  output logic [bvc_pkg::QW-1:0]        quo_x_o,
  output logic [bvc_pkg::QW-1:0]        quo_y_o,
  output bvc_pkg::dv_side_t             side_o
);
  import bvc_pkg::*;

  logic [DIV_STAGES-1:0] vld_q;
  logic [NUMW-1:0]       rx_q [DIV_STAGES];
  logic [NUMW-1:0]       ry_q [DIV_STAGES];
  logic [QW-1:0]         qx_q [DIV_STAGES];
  logic [QW-1:0]         qy_q [DIV_STAGES];
  logic [ROOTW-1:0]      dn_q [DIV_STAGES];
  dv_side_t              sd_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int unsigned SH = DIV_STAGES - 1 - s;
    localparam logic [QW-1:0] QBIT = QW'(1) << SH;
    logic [NUMW-1:0]  rx_in, ry_in, dsh;
    logic [QW-1:0]    qx_in, qy_in;
    logic [ROOTW-1:0] dn_in;
    dv_side_t         sd_in;
    logic             vld_in;

    if (s == 0) begin : g_first
      assign rx_in  = num_x_i;
      assign ry_in  = num_y_i;
      assign qx_in  = '0;
      assign qy_in  = '0;
      assign dn_in  = den_i;
      assign sd_in  = side_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rx_in  = rx_q[s-1];
      assign ry_in  = ry_q[s-1];
      assign qx_in  = qx_q[s-1];
      assign qy_in  = qy_q[s-1];
      assign dn_in  = dn_q[s-1];
      assign sd_in  = sd_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    assign dsh = NUMW'(dn_in) << SH;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dn_q[s] <= dn_in;
      sd_q[s] <= sd_in;
      if (rx_in >= dsh) begin
        rx_q[s] <= rx_in - dsh;
        qx_q[s] <= qx_in | QBIT;
      end else begin
        rx_q[s] <= rx_in;
        qx_q[s] <= qx_in;
      end
      if (ry_in >= dsh) begin
        ry_q[s] <= ry_in - dsh;
        qy_q[s] <= qy_in | QBIT;
      end else begin
        ry_q[s] <= ry_in;
        qy_q[s] <= qy_in;
      end
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quo_x_o = qx_q[DIV_STAGES-1];
  assign quo_y_o = qy_q[DIV_STAGES-1];
  assign side_o  = sd_q[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== hdl/box_vs_collider_contact.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_vs_collider_contact
// contact test of a static box against a circle or box collider
// ----------------------------------------------------------------------------
// a request (static box plus collider) is taken on any clock edge with
// start_i high; busy_o stays low, so a new request may enter every cycle
// each request gives one result on result_o, marked by done_o for exactly
// one cycle, in request order
// the pipeline is two front stages (clamp and overlap, then squares), 25
// square root stages at one root bit each, one decision stage, 15 divider
// stages at one normal bit each, and the output register
// throughput is one request per cycle, set by the fully pipelined root and
// divider chains
// reset clears all valid bits, so no result appears until a request enters
// the receiver cannot stall: results leave on their cycle
// ----------------------------------------------------------------------------
module box_vs_collider_contact (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire bvc_pkg::req_t  req_i,
  output logic                busy_o,
  output logic                done_o,
  output bvc_pkg::res_t       result_o
);
  import bvc_pkg::*;

  logic             fr_valid;
  logic [SUMW-1:0]  fr_sum;
  sq_side_t         fr_side;
  logic             sq_valid;
  logic [ROOTW-1:0] sq_root;
  sq_side_t         sq_side;

  logic             c_valid_q;
  logic [NUMW-1:0]  c_numx_q, c_numy_q;
  logic [ROOTW-1:0] c_den_q;
  dv_side_t         c_side_q;
  dv_side_t         c_side_d;
  logic [23:0]      absx, absy;
  logic             circ_hit;

  logic             dv_valid;
  logic [QW-1:0]    dv_qx, dv_qy;
  dv_side_t         dv_side;
  res_t             res_d;

  assign busy_o = 1'b0;

  bvc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .req_i   (req_i),
    .valid_o (fr_valid),
    .sum_o   (fr_sum),
    .side_o  (fr_side)
  );

  bvc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .sum_i   (fr_sum),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // decision stage
  always_comb begin
    absx     = sq_side.dx[DW-1] ? 24'(-sq_side.dx) : sq_side.dx[23:0];
    absy     = sq_side.dy[DW-1] ? 24'(-sq_side.dy) : sq_side.dy[23:0];
    circ_hit = sq_root < {2'b0, sq_side.radius};
    c_side_d = '0;
    c_side_d.neg_x = sq_side.dx[DW-1];
    c_side_d.neg_y = sq_side.dy[DW-1];
    if (!sq_side.is_circle) begin
      c_side_d.res = sq_side.box_res;
    end else if (circ_hit) begin
      c_side_d.res.colliding = 1'b1;
      c_side_d.res.depth     = sq_side.radius - sq_root[22:0];
      if (sq_root == '0) begin
        c_side_d.res.normal_y = NEG_NORMAL;
      end else begin
        c_side_d.use_div = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      done_o    <= 1'b0;
    end else begin
      c_valid_q <= sq_valid;
      done_o    <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    c_numx_q <= {2'b0, absx, 14'b0};
    c_numy_q <= {2'b0, absy, 14'b0};
    c_den_q  <= sq_root;
    c_side_q <= c_side_d;
    result_o <= res_d;
  end

  bvc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid_q),
    .num_x_i (c_numx_q),
    .num_y_i (c_numy_q),
    .den_i   (c_den_q),
    .side_i  (c_side_q),
    .valid_o (dv_valid),
    .quo_x_o (dv_qx),
    .quo_y_o (dv_qy),
    .side_o  (dv_side)
  );

  always_comb begin
    res_d = dv_side.res;
    if (dv_side.use_div) begin
      res_d.normal_x = dv_side.neg_x ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
      res_d.normal_y = dv_side.neg_y ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
    end
  end

  a_no_hit_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.colliding |->
      result_o.normal_x == '0 && result_o.normal_y == '0 && result_o.depth == '0)
    else $error("non-colliding result carries data");

  a_hit_normal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.colliding |->
      result_o.normal_x != '0 || result_o.normal_y != '0)
    else $error("colliding result without normal");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(LATENCY) done_o)
    else $error("request lost in pipeline");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives contact requests of a static box against circle and box colliders,
// predicts each contact result in a behavioural model and checks the results
// in order as they leave the pipeline, under several idle patterns
// ----------------------------------------------------------------------------
module tb;
  import bvc_pkg::*;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  req_t  req_i = '0;
  logic  busy_o;
  logic  done_o;
  res_t  result_o;

  res_t  pending_contacts[$];
  int    errors = 0;
  int    idle_pct = 0;

  box_vs_collider_contact DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic longint floor_root(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic res_t contact_of(req_t q);
    res_t   o;
    longint bx0, by0, bx1, by1, cx, cy, qx, qy, dx, dy, root_len, dep, ovx, ovy;
    longint nx, ny, sx, sy;
    bit     hit;
    o = '0;
    hit = 0;
    nx = 0;
    ny = 0;
    dep = 0;
    bx0 = q.box_min_x;
    by0 = q.box_min_y;
    bx1 = q.box_max_x;
    by1 = q.box_max_y;
    cx = q.center_x;
    cy = q.center_y;
    sx = longint'(q.size_x);
    sy = longint'(q.size_y);
    if (q.is_circle) begin
      qx = (cx < bx1) ? cx : bx1;
      qx = (bx0 > qx) ? bx0 : qx;
      qy = (cy < by1) ? cy : by1;
      qy = (by0 > qy) ? by0 : qy;
      dx = cx - qx;
      dy = cy - qy;
      root_len = floor_root(dx * dx + dy * dy);
      if (root_len < longint'(q.radius)) begin
        hit = 1;
        dep = longint'(q.radius) - root_len;
        if (root_len == 0) begin
          ny = -16384;
        end else begin
          nx = (dx * 16384) / root_len;
          ny = (dy * 16384) / root_len;
        end
      end
    end else begin
      ovx = ((2 * bx1 < 2 * cx + sx) ? 2 * bx1 : 2 * cx + sx)
          - ((2 * bx0 > 2 * cx - sx) ? 2 * bx0 : 2 * cx - sx);
      ovy = ((2 * by1 < 2 * cy + sy) ? 2 * by1 : 2 * cy + sy)
          - ((2 * by0 > 2 * cy - sy) ? 2 * by0 : 2 * cy - sy);
      if (ovx > 0 && ovy > 0) begin
        hit = 1;
        if (ovx < ovy) begin
          nx = (2 * cx < bx0 + bx1) ? -16384 : 16384;
          dep = ovx >>> 1;
        end else begin
          ny = (2 * cy < by0 + by1) ? -16384 : 16384;
          dep = ovy >>> 1;
        end
      end
    end
    if (hit) begin
      o.colliding = 1'b1;
      o.normal_x = nx[15:0];
      o.normal_y = ny[15:0];
      o.depth = (dep > 8388607) ? 23'h7fffff : (dep < 0 ? 23'd0 : dep[22:0]);
    end
    return o;
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (done_o) begin
      if (pending_contacts.size() == 0) begin
        $display("%0t unexpected result %h", $time, result_o);
        errors++;
      end else begin
        want = pending_contacts.pop_front();
        if (want.colliding !== result_o.colliding)
          $display("%0t colliding exp %b got %b", $time, want.colliding,
                   result_o.colliding);
        if (want.normal_x !== result_o.normal_x)
          $display("%0t normal_x exp %0d got %0d", $time, want.normal_x,
                   result_o.normal_x);
        if (want.normal_y !== result_o.normal_y)
          $display("%0t normal_y exp %0d got %0d", $time, want.normal_y,
                   result_o.normal_y);
        if (want.depth !== result_o.depth)
          $display("%0t depth exp %0d got %0d", $time, want.depth,
                   result_o.depth);
        if (want !== result_o) errors++;
      end
    end
  end

  task automatic send_request(req_t q);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_contacts = {pending_contacts, contact_of(q)};
  endtask

  function automatic logic [23:0] rand24();
    return 24'($urandom());
  endfunction

  // mostly small coordinates near the box so contacts are frequent
  function automatic req_t random_request();
    req_t q;
    int   span;
    q.is_circle = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      q.box_min_x = rand24(); q.box_min_y = rand24();
      q.box_max_x = rand24(); q.box_max_y = rand24();
      q.center_x = rand24(); q.center_y = rand24();
      q.radius = 23'($urandom()); q.size_x = 23'($urandom());
      q.size_y = 23'($urandom());
    end else begin
      span = 1 << $urandom_range(4, 20);
      q.box_min_x = 24'($signed($urandom_range(2 * span)) - span);
      q.box_min_y = 24'($signed($urandom_range(2 * span)) - span);
      q.box_max_x = 24'(q.box_min_x + $urandom_range(2 * span));
      q.box_max_y = 24'(q.box_min_y + $urandom_range(2 * span));
      q.center_x = 24'($signed($urandom_range(4 * span)) - 2 * span);
      q.center_y = 24'($signed($urandom_range(4 * span)) - 2 * span);
      q.radius = 23'($urandom_range(2 * span));
      q.size_x = 23'($urandom_range(3 * span));
      q.size_y = 23'($urandom_range(3 * span));
    end
    return q;
  endfunction

  function automatic req_t mk(bit c, int x0, int y0, int x1, int y1, int cx,
                              int cy, int r, int sx, int sy);
    req_t q;
    q.is_circle = c;
    q.box_min_x = 24'(x0); q.box_min_y = 24'(y0);
    q.box_max_x = 24'(x1); q.box_max_y = 24'(y1);
    q.center_x = 24'(cx); q.center_y = 24'(cy);
    q.radius = 23'(r); q.size_x = 23'(sx); q.size_y = 23'(sy);
    return q;
  endfunction

  task automatic wait_drained();
    int n;
    n = 0;
    start_i <= 1'b0;
    while (pending_contacts.size() != 0) @(posedge clk_i);
    while (n < LATENCY + 4) begin
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_request(mk(1, 0, 0, 2560, 2560, 1280, 1280, 256, 0, 0));
    send_request(mk(1, 0, 0, 2560, 2560, 3000, 1280, 1000, 7, 7));
    send_request(mk(1, 0, 0, 2560, 2560, 3000, 3000, 1000, 0, 0));
    send_request(mk(1, 0, 0, 2560, 2560, -600, -600, 500, 0, 0));
    send_request(mk(1, 0, 0, 2560, 2560, 3000, 1280, 440, 0, 0));
    send_request(mk(1, 2560, 2560, 0, 0, 1280, 1280, 5000, 0, 0));
    send_request(mk(1, -8388608, -8388608, 8388607, 8388607, 0, 0,
                    8388607, 0, 0));
    send_request(mk(1, -8388608, -8388608, -8388608, -8388608, 8388607,
                    8388607, 8388607, 8388607, 8388607));
    send_request(mk(1, 8388607, 8388607, 8388607, 8388607, -8388608,
                    -8388608, 8388607, 0, 0));
    send_request(mk(0, 0, 0, 2560, 2560, 1280, 1280, 9, 512, 512));
    send_request(mk(0, 0, 0, 2560, 2560, 2600, 1280, 0, 512, 2000));
    send_request(mk(0, 0, 0, 2560, 2560, -40, 1280, 0, 512, 2000));
    send_request(mk(0, 0, 0, 2560, 2560, 1280, 2600, 0, 2000, 512));
    send_request(mk(0, 0, 0, 2560, 2560, 1280, -40, 0, 2000, 512));
    send_request(mk(0, 0, 0, 2560, 2560, 2700, 2700, 0, 512, 512));
    send_request(mk(0, 0, 0, 2560, 2560, 4000, 4000, 0, 512, 512));
    send_request(mk(0, 2560, 2560, 0, 0, 1280, 1280, 0, 8000, 8000));
    send_request(mk(0, -8388608, -8388608, 8388607, 8388607, 0, 0, 0,
                    8388607, 8388607));
    send_request(mk(0, -8388608, -8388608, 8388607, 8388607, 8388607,
                    -8388608, 8388607, 8388607, 8388607));
    send_request(mk(0, 0, 0, 2560, 2560, 1280, 1280, 0, 0, 0));
    wait_drained();
  endtask

  task automatic test_random(int pct, int count);
    idle_pct = pct;
    repeat (count) send_request(random_request());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(0, 180);
    test_random(66, 160);
    test_random(23, 150);
    test_random(0, 160);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
